// File: rtl/gregorian_date_day_offset_top_macros.svh
// Assertion macros for the Gregorian date offset block.
// Used by the port checker; no other dependencies.
`ifndef GREGORIAN_DATE_DAY_OFFSET_TOP_MACROS_SVH
`define GREGORIAN_DATE_DAY_OFFSET_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define GDDO_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define GDDO_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: rtl/gddo_pkg.sv
// Shared types, constants and calendar functions for the date offset block.
// No dependencies; imported by the controller, datapath, top level and checker.
package gddo_pkg;

    localparam int YearW  = 16;
    localparam int MonthW = 4;
    localparam int DayW   = 5;
    localparam int OffW   = 16;
    // working day count: held day plus any offset, signed
    localparam int AccW   = 17;

    localparam int SDataW = 48;
    localparam int MDataW = 32;

    localparam logic [MonthW-1:0] MonthJan = 4'd1;
    localparam logic [MonthW-1:0] MonthFeb = 4'd2;
    localparam logic [MonthW-1:0] MonthDec = 4'd12;

    localparam logic [DayW-1:0] DaysLong = 5'd31;
    localparam logic [DayW-1:0] DaysFeb  = 5'd28;

    localparam logic [YearW-1:0] YearMax = 16'hFFFF;

    // modular inverse of 25 mod 2^16; y is a multiple of 25 when y*inv <= 65535/25
    localparam logic [YearW-1:0] Inv25    = 16'd23593;
    localparam logic [YearW-1:0] Div25Max = 16'd2621;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_ADD  = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE       = 6'b000001,
        ST_LOAD_WAIT  = 6'b000010,
        ST_LOAD_CLAMP = 6'b000100,
        ST_STEP       = 6'b001000,
        ST_SETTLE     = 6'b010000,
        ST_FINISH     = 6'b100000
    } gddo_state_t;

    typedef struct packed {
        logic load;
        logic start_add;
        logic clamp;
        logic step;
        logic capture;
    } gddo_cmd_t;

    typedef struct packed {
        logic norm_done;
    } gddo_status_t;

    // Month length for a month within the held year.
    function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
                                                   input logic leap);
        logic [DayW-1:0] n;
        begin
            case (m)
                4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
                4'd2:                    n = leap ? DaysFeb + 5'd1 : DaysFeb;
                default:                 n = DaysLong;
            endcase
            return n;
        end
    endfunction

endpackage

// File: rtl/gddo_ctrl.sv
// Sequencer for the date offset block: input/output handshake and step control.
// Depends on gddo_pkg; drives commands into gddo_dp.
module gddo_ctrl import gddo_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic         s_mode,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  gddo_status_t status,
    output gddo_cmd_t    cmd
);

    gddo_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cmd          = '0;
        s_tready     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_mode == MODE_LOAD) begin
                        cmd.load   = 1'b1;
                        state_next = ST_LOAD_WAIT;
                    end else begin
                        cmd.start_add = 1'b1;
                        state_next    = ST_STEP;
                    end
                end
            end
            // let the leap flag follow the new year
            ST_LOAD_WAIT: state_next = ST_LOAD_CLAMP;
            ST_LOAD_CLAMP: begin
                cmd.clamp  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_STEP: begin
                if (status.norm_done) begin
                    state_next = ST_SETTLE;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            ST_SETTLE: state_next = ST_FINISH;
            ST_FINISH: begin
                // hold until the output word is free
                if (!m_valid_reg || m_tready) begin
                    cmd.capture  = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

// File: rtl/gddo_dp.sv
// Datapath for the date offset block: held date, leap flag, month walk, output word.
// Depends on gddo_pkg; commanded by gddo_ctrl.
module gddo_dp import gddo_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [YearW-1:0]  load_year,
    input  logic [MonthW-1:0] load_month,
    input  logic [DayW-1:0]   load_day,
    input  logic [OffW-1:0]   day_offset,
    input  gddo_cmd_t         cmd,
    output gddo_status_t      status,
    output logic [MDataW-1:0] m_tdata
);

    logic [YearW-1:0]        year_reg, year_next;
    logic [MonthW-1:0]       month_reg, month_next;
    logic signed [AccW-1:0]  day_reg, day_next;
    logic                    leap_reg, leap_next;
    logic                    wrap_reg, wrap_next;
    logic [MDataW-1:0]       out_reg;

    logic [YearW-1:0]        year_prod;
    logic                    div25;
    logic [DayW-1:0]         cur_len;
    logic [DayW-1:0]         prev_len;
    logic signed [AccW-1:0]  cur_len_s;
    logic signed [AccW-1:0]  prev_len_s;
    logic                    under;
    logic                    over;
    logic [MonthW-1:0]       ld_month;
    logic [DayW-1:0]         ld_day;

    // leap rule: div by 4 and (not by 25, or by 16)
    assign year_prod = year_reg * Inv25;
    assign div25     = (year_prod <= Div25Max);
    assign leap_next = (year_reg[1:0] == 2'b00) && (!div25 || (year_reg[3:0] == 4'h0));

    assign cur_len    = month_days(month_reg, leap_reg);
    // December always precedes January
    assign prev_len   = (month_reg == MonthJan) ? DaysLong
                        : month_days(month_reg - 4'd1, leap_reg);
    assign cur_len_s  = $signed({{(AccW-DayW){1'b0}}, cur_len});
    assign prev_len_s = $signed({{(AccW-DayW){1'b0}}, prev_len});
    assign under      = (day_reg <= $signed({AccW{1'b0}}));
    assign over       = (day_reg > cur_len_s);

    assign status.norm_done = !under && !over;

    assign ld_month = (load_month == 4'd0) ? MonthJan
                      : ((load_month > MonthDec) ? MonthDec : load_month);
    assign ld_day   = (load_day == 5'd0) ? 5'd1 : load_day;

    always_comb begin
        year_next  = year_reg;
        month_next = month_reg;
        day_next   = day_reg;
        wrap_next  = wrap_reg;
        if (cmd.load) begin
            year_next  = load_year;
            month_next = ld_month;
            day_next   = $signed({{(AccW-DayW){1'b0}}, ld_day});
            wrap_next  = 1'b0;
        end else if (cmd.start_add) begin
            day_next  = day_reg + $signed({day_offset[OffW-1], day_offset});
            wrap_next = 1'b0;
        end else if (cmd.clamp) begin
            if (over) begin
                day_next = cur_len_s;
            end
        end else if (cmd.step) begin
            if (under) begin
                // borrow the previous month
                day_next = day_reg + prev_len_s;
                if (month_reg == MonthJan) begin
                    month_next = MonthDec;
                    year_next  = year_reg - 16'd1;
                    if (year_reg == '0) begin
                        wrap_next = 1'b1;
                    end
                end else begin
                    month_next = month_reg - 4'd1;
                end
            end else begin
                // carry out the current month
                day_next = day_reg - cur_len_s;
                if (month_reg == MonthDec) begin
                    month_next = MonthJan;
                    year_next  = year_reg + 16'd1;
                    if (year_reg == YearMax) begin
                        wrap_next = 1'b1;
                    end
                end else begin
                    month_next = month_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            year_reg  <= '0;
            month_reg <= MonthJan;
            day_reg   <= $signed({{(AccW-1){1'b0}}, 1'b1});
            leap_reg  <= 1'b1;
            wrap_reg  <= 1'b0;
        end else begin
            year_reg  <= year_next;
            month_reg <= month_next;
            day_reg   <= day_next;
            leap_reg  <= leap_next;
            wrap_reg  <= wrap_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            out_reg <= {5'b0, wrap_reg, leap_reg, day_reg[DayW-1:0], month_reg, year_reg};
        end
    end

    assign m_tdata = out_reg;

endmodule

// File: rtl/gregorian_date_day_offset_top.sv
// Gregorian date register with signed day-offset add, normalized one month per cycle.
// Load word: states LOAD_WAIT, LOAD_CLAMP, FINISH, then m_tvalid rises. Add word: STEP walks
// one month at a time until the day is in range, then SETTLE and FINISH; FINISH waits while
// the output word is still held. One word in flight; a new one is taken even while a result waits.
// Synchronous active-low reset: date 0000-01-01, no result pending.
// Depends on gddo_pkg, gddo_ctrl and gddo_dp.
module gregorian_date_day_offset_top import gddo_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [SDataW-1:0] s_tdata,  // load_year, load_month, load_day, day_offset, pad
    input  logic              s_tuser,  // mode
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [MDataW-1:0] m_tdata   // cur_year, cur_month, cur_day, leap_flag,
                                        // year_wrapped, pad
);

    gddo_cmd_t    cmd;
    gddo_status_t status;

    gddo_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_mode   (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gddo_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_year  (s_tdata[15:0]),
        .load_month (s_tdata[19:16]),
        .load_day   (s_tdata[24:20]),
        .day_offset (s_tdata[40:25]),
        .cmd        (cmd),
        .status     (status),
        .m_tdata    (m_tdata)
    );

endmodule

// File: rtl/gddo_checker.sv
// Port checker for the date offset block, bound to the top level.
// Depends on gddo_pkg and the assertion macro header.
`include "gregorian_date_day_offset_top_macros.svh"

module gddo_checker import gddo_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [MDataW-1:0] m_tdata
);

    `GDDO_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_tvalid, "result valid after reset")
    `GDDO_ASSERT(a_hold_stall, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stall")
    `GDDO_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "took two words at once")
    `GDDO_ASSERT(a_month_range, m_tvalid |-> m_tdata[19:16] - 4'd1 < MonthDec, "bad month")
    `GDDO_ASSERT(a_day_range, m_tvalid |-> m_tdata[24:20] != 5'd0, "day is zero")

endmodule

bind gregorian_date_day_offset_top gddo_checker u_gddo_checker (.*);
